>>> hw/rtl/idu_pkg.sv
// Shared types, opcode codes and format classification for the instruction decoder.
// Used by the channel interfaces and by every decoder module; depends on nothing.
`default_nettype none

package idu_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OP_W     = 6;
    localparam int unsigned REG_W    = 5;
    localparam int unsigned NUM_REGS = 32;
    localparam int unsigned IMM16_W  = 16;
    localparam int unsigned IMM26_W  = 26;

    typedef logic [1:0] t_fmt;
    localparam t_fmt FMT_R   = 2'd0;
    localparam t_fmt FMT_I   = 2'd1;
    localparam t_fmt FMT_J   = 2'd2;
    localparam t_fmt FMT_BAD = 2'd3;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_JMP    = 6'd16;
    localparam t_op OP_R_ALU0 = 6'd17;
    localparam t_op OP_I_CMP0 = 6'd18;
    localparam t_op OP_I_RD0  = 6'd19;
    localparam t_op OP_I_RD1  = 6'd20;
    localparam t_op OP_R_ALU1 = 6'd21;
    localparam t_op OP_I_CMP1 = 6'd22;
    localparam t_op OP_I_LD0  = 6'd23;
    localparam t_op OP_R_SH0  = 6'd24;
    localparam t_op OP_R_SH1  = 6'd25;
    localparam t_op OP_R_SH2  = 6'd26;
    localparam t_op OP_R_ALU2 = 6'd27;
    localparam t_op OP_R_LO   = 6'd48;
    localparam t_op OP_R_HI   = 6'd55;
    localparam t_op OP_I_LO   = 6'd56;
    localparam t_op OP_I_HI   = 6'd59;

    typedef logic [NUM_REGS-1:0] t_mask;

    // Which register fields the instruction reads and writes.
    typedef struct packed {
        logic rd_rs;
        logic rd_rt;
        logic wr_rd;
        logic wr_rt;
    } t_reg_use;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_fmt              fmt;
        t_reg_use          regs;
    } t_s1;

    typedef struct packed {
        t_op                opcode;
        t_fmt               fmt;
        logic [REG_W-1:0]   rs;
        logic [REG_W-1:0]   rt;
        logic [REG_W-1:0]   rd;
        logic [REG_W-1:0]   sh;
        logic [IMM16_W-1:0] imm16;
        logic [IMM26_W-1:0] imm26;
        t_mask              read_raw;
        t_mask              write;
    } t_s2;

    typedef struct packed {
        t_op                opcode;
        t_fmt               fmt;
        logic [REG_W-1:0]   rs;
        logic [REG_W-1:0]   rt;
        logic [REG_W-1:0]   rd;
        logic [REG_W-1:0]   sh;
        logic [IMM16_W-1:0] imm16;
        logic [IMM26_W-1:0] imm26;
        t_mask              read_mask;
        t_mask              write_mask;
    } t_dec;

    function automatic t_fmt classify(input t_op op);
        t_fmt f;
        f = FMT_BAD;
        case (op) inside
            OP_JMP: f = FMT_J;
            OP_R_ALU0, OP_R_ALU1, [OP_R_SH0:OP_R_ALU2], [OP_R_LO:OP_R_HI]: f = FMT_R;
            [OP_I_CMP0:OP_I_RD1], OP_I_CMP1, OP_I_LD0, [OP_I_LO:OP_I_HI]: f = FMT_I;
            default: f = FMT_BAD;
        endcase
        return f;
    endfunction

    function automatic t_reg_use reg_use(input t_op op, input t_fmt f);
        t_reg_use u;
        u = '0;
        case (f)
            FMT_R: begin
                u.wr_rd = 1'b1;
                u.rd_rt = 1'b1;
                u.rd_rs = !(op == OP_R_SH0 || op == OP_R_SH1 || op == OP_R_SH2);
            end
            FMT_I: begin
                u.rd_rs = 1'b1;
                case (op) inside
                    OP_I_CMP0, OP_I_CMP1: u.rd_rt = 1'b1;
                    OP_I_RD0, OP_I_RD1:   u.rd_rt = 1'b0;
                    default:              u.wr_rt = 1'b1;
                endcase
            end
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/idu_if.sv
// Valid/ready channel interfaces for instruction words and decoded results.
// Depends on idu_pkg for field widths and types.
`default_nettype none

interface idu_in_if
    import idu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface idu_out_if
    import idu_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [1:0]          format;
    logic [REG_W-1:0]    src_reg_a;
    logic [REG_W-1:0]    src_reg_b;
    logic [REG_W-1:0]    dest_reg;
    logic [REG_W-1:0]    shift_amount;
    logic [IMM16_W-1:0]  imm_short;
    logic [IMM26_W-1:0]  imm_long;
    logic [NUM_REGS-1:0] read_mask;
    logic [NUM_REGS-1:0] write_mask;

    modport source (
        output valid, output opcode, output format, output src_reg_a, output src_reg_b,
        output dest_reg, output shift_amount, output imm_short, output imm_long,
        output read_mask, output write_mask, input ready
    );
    modport sink (
        input valid, input opcode, input format, input src_reg_a, input src_reg_b,
        input dest_reg, input shift_amount, input imm_short, input imm_long,
        input read_mask, input write_mask, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/idu_classify.sv
// First pipeline stage: classifies the opcode into a format and register-use flags.
// Depends on idu_pkg.
`default_nettype none

module idu_classify
    import idu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [WORD_W-1:0] i_word,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_s1                    o_data
);

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;
    t_op  w_op;

    assign w_op          = i_word[WORD_W-1 -: OP_W];
    assign n_data.word   = i_word;
    assign n_data.fmt    = classify(w_op);
    assign n_data.regs   = reg_use(w_op, n_data.fmt);

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/idu_extract.sv
// Second pipeline stage: extracts the fields of the format and builds raw register masks.
// Depends on idu_pkg.
`default_nettype none

module idu_extract
    import idu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_s1  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_s2       o_data
);

    logic r_valid;
    t_s2  r_data;
    t_s2  n_data;
    logic w_is_r;
    logic w_is_ri;

    assign w_is_r  = (i_data.fmt == FMT_R);
    assign w_is_ri = w_is_r || (i_data.fmt == FMT_I);

    always_comb begin
        n_data          = '0;
        n_data.opcode   = i_data.word[WORD_W-1 -: OP_W];
        n_data.fmt      = i_data.fmt;
        n_data.rs       = w_is_ri ? i_data.word[25:21] : '0;
        n_data.rt       = w_is_ri ? i_data.word[20:16] : '0;
        n_data.rd       = w_is_r ? i_data.word[15:11] : '0;
        n_data.sh       = w_is_r ? i_data.word[10:6] : '0;
        n_data.imm16    = (i_data.fmt == FMT_I) ? i_data.word[IMM16_W-1:0] : '0;
        n_data.imm26    = (i_data.fmt == FMT_J) ? i_data.word[IMM26_W-1:0] : '0;
        if (i_data.regs.rd_rs) begin
            n_data.read_raw[i_data.word[25:21]] = 1'b1;
        end
        if (i_data.regs.rd_rt) begin
            n_data.read_raw[i_data.word[20:16]] = 1'b1;
        end
        if (i_data.regs.wr_rd) begin
            n_data.write[i_data.word[15:11]] = 1'b1;
        end
        if (i_data.regs.wr_rt) begin
            n_data.write[i_data.word[20:16]] = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/idu_mask.sv
// Third pipeline stage: clears read marks covered by a write mark and holds the result.
// Depends on idu_pkg.
`default_nettype none

module idu_mask
    import idu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_s2  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_dec      o_data
);

    logic r_valid;
    t_dec r_data;
    t_dec n_data;

    always_comb begin
        n_data.opcode     = i_data.opcode;
        n_data.fmt        = i_data.fmt;
        n_data.rs         = i_data.rs;
        n_data.rt         = i_data.rt;
        n_data.rd         = i_data.rd;
        n_data.sh         = i_data.sh;
        n_data.imm16      = i_data.imm16;
        n_data.imm26      = i_data.imm26;
        n_data.read_mask  = i_data.read_raw & ~i_data.write;
        n_data.write_mask = i_data.write;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/instruction_decode_with_reg_use_unit.sv
// Top level of the instruction decoder with register-use masks.
// Depends on idu_pkg, idu_if, idu_classify, idu_extract and idu_mask.
//
//   Channel   Port      Dir  Payload
//   --------  --------  ---  ------------------------------------------------
//   input     i_instr   in   instr_word
//   output    o_dec     out  opcode, format, fields, read_mask, write_mask
//
// Each transaction passes in order through the registered stages classify,
// extract and mask, and one transaction is accepted every cycle unless stalled.
// Each stage accepts when it is empty or when its result moves on this cycle,
// so a stall on the output fills the stages and then stops the input.
// The synchronous reset clears only the stage valid bits.
`default_nettype none

module instruction_decode_with_reg_use_unit
    import idu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    idu_in_if.sink    i_instr,
    idu_out_if.source o_dec
);

    logic w_s1_valid;
    logic w_s1_ready;
    t_s1  w_s1_data;
    logic w_s2_valid;
    logic w_s2_ready;
    t_s2  w_s2_data;
    t_dec w_s3_data;

    idu_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_instr.valid),
        .o_ready (i_instr.ready),
        .i_word  (i_instr.instr_word),
        .o_valid (w_s1_valid),
        .i_ready (w_s1_ready),
        .o_data  (w_s1_data)
    );

    idu_extract u_extract (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1_data),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2_data)
    );

    idu_mask u_mask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s2_data),
        .o_valid (o_dec.valid),
        .i_ready (o_dec.ready),
        .o_data  (w_s3_data)
    );

    assign o_dec.opcode       = w_s3_data.opcode;
    assign o_dec.format       = w_s3_data.fmt;
    assign o_dec.src_reg_a    = w_s3_data.rs;
    assign o_dec.src_reg_b    = w_s3_data.rt;
    assign o_dec.dest_reg     = w_s3_data.rd;
    assign o_dec.shift_amount = w_s3_data.sh;
    assign o_dec.imm_short    = w_s3_data.imm16;
    assign o_dec.imm_long     = w_s3_data.imm26;
    assign o_dec.read_mask    = w_s3_data.read_mask;
    assign o_dec.write_mask   = w_s3_data.write_mask;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid |-> ((o_dec.read_mask & o_dec.write_mask) == '0))
        else $error("read and write masks overlap");

    a_write_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.valid |-> $onehot0(o_dec.write_mask))
        else $error("more than one register written");

    a_no_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dec.valid && (o_dec.format == FMT_J || o_dec.format == FMT_BAD))
        |-> (o_dec.read_mask == '0 && o_dec.write_mask == '0 && o_dec.src_reg_a == '0))
        else $error("jump or invalid format carries register marks");

    a_r_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dec.valid && o_dec.format != FMT_R)
        |-> (o_dec.dest_reg == '0 && o_dec.shift_amount == '0))
        else $error("rd or shamt set outside R format");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_valid && !w_s2_ready) |=> (w_s2_valid && $stable(w_s2_data)))
        else $error("stalled extract stage changed");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for instruction_decode_with_reg_use_unit: random and directed
// instruction words go in, decoded fields and register masks are checked against a predictor.
// Depends on idu_pkg, the idu_if channel interfaces and the decoder RTL.
`timescale 1ns / 100ps

module testbench;
    import idu_pkg::*;

    localparam int MAX_CYCLES   = 200000;
    localparam int RANDOM_WORDS = 550;
    localparam int CALM_TAIL    = 60;

    logic i_clk;
    logic i_rst_n;

    idu_in_if  instr_bus ();
    idu_out_if dec_bus ();

    instruction_decode_with_reg_use_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_bus),
        .o_dec   (dec_bus)
    );

    logic [WORD_W-1:0] pending_words[$];
    t_dec              expected_decodes[$];
    int                err_count   = 0;
    int                result_num  = 0;
    int                cycle_count = 0;
    int                in_gap      = 0;
    int                out_gap     = 0;
    logic              in_taken    = 1'b0;

    function automatic t_dec decode_word(input logic [WORD_W-1:0] w);
        t_dec d;
        t_op  op;
        logic uses_rs, uses_rt, writes_rd, writes_rt;
        t_mask rmask, wmask;
        d = '0;
        op = w[31:26];
        d.opcode = op;
        d.fmt = FMT_BAD;
        uses_rs = 1'b0;
        uses_rt = 1'b0;
        writes_rd = 1'b0;
        writes_rt = 1'b0;
        case (op) inside
            OP_JMP: d.fmt = FMT_J;
            OP_R_SH0, OP_R_SH1, OP_R_SH2: begin
                d.fmt = FMT_R;
                uses_rt = 1'b1;
                writes_rd = 1'b1;
            end
            OP_R_ALU0, OP_R_ALU1, OP_R_ALU2, [OP_R_LO:OP_R_HI]: begin
                d.fmt = FMT_R;
                uses_rs = 1'b1;
                uses_rt = 1'b1;
                writes_rd = 1'b1;
            end
            OP_I_CMP0, OP_I_CMP1: begin
                d.fmt = FMT_I;
                uses_rs = 1'b1;
                uses_rt = 1'b1;
            end
            OP_I_RD0, OP_I_RD1: begin
                d.fmt = FMT_I;
                uses_rs = 1'b1;
            end
            OP_I_LD0, [OP_I_LO:OP_I_HI]: begin
                d.fmt = FMT_I;
                uses_rs = 1'b1;
                writes_rt = 1'b1;
            end
            default: d.fmt = FMT_BAD;
        endcase
        if (d.fmt == FMT_R || d.fmt == FMT_I) begin
            d.rs = w[25:21];
            d.rt = w[20:16];
        end
        if (d.fmt == FMT_R) begin
            d.rd = w[15:11];
            d.sh = w[10:6];
        end
        if (d.fmt == FMT_I) begin
            d.imm16 = w[15:0];
        end
        if (d.fmt == FMT_J) begin
            d.imm26 = w[25:0];
        end
        rmask = '0;
        wmask = '0;
        if (uses_rs) rmask |= t_mask'(1) << d.rs;
        if (uses_rt) rmask |= t_mask'(1) << d.rt;
        if (writes_rd) wmask |= t_mask'(1) << d.rd;
        if (writes_rt) wmask |= t_mask'(1) << d.rt;
        d.read_mask = rmask & ~wmask;
        d.write_mask = wmask;
        return d;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        int idx;
        w = $urandom();
        if ($urandom_range(0, 99) < 85) begin
            idx = $urandom_range(0, 23);
            w[31:26] = (idx < 12) ? t_op'(OP_JMP + idx) : t_op'(OP_R_LO + idx - 12);
        end else begin
            w[31:26] = t_op'($urandom_range(0, 63));
        end
        // Force register collisions now and then so write-over-read gets exercised.
        case ($urandom_range(0, 7))
            0: w[15:11] = w[25:21];
            1: w[15:11] = w[20:16];
            2: w[20:16] = w[25:21];
            default: ;
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: result %0d %s got 0x%08h expected 0x%08h",
                 result_num, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        instr_bus.valid = 1'b0;
        instr_bus.instr_word = '0;
        dec_bus.ready = 1'b0;
        i_rst_n = 1'b0;

        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'hffff_ffff);
        pending_words.push_back({OP_JMP, 26'h3ff_ffff});
        pending_words.push_back({OP_JMP, 26'h000_0000});
        pending_words.push_back({OP_R_ALU0, 26'($urandom())});
        pending_words.push_back({OP_I_CMP0, 26'($urandom())});
        pending_words.push_back({OP_I_RD0, 26'($urandom())});
        pending_words.push_back({OP_I_RD1, 26'($urandom())});
        pending_words.push_back({OP_R_ALU1, 26'($urandom())});
        pending_words.push_back({OP_I_CMP1, 26'($urandom())});
        pending_words.push_back({OP_I_LD0, 26'($urandom())});
        pending_words.push_back({OP_R_SH0, 26'($urandom())});
        pending_words.push_back({OP_R_SH1, 26'($urandom())});
        pending_words.push_back({OP_R_SH2, 26'($urandom())});
        pending_words.push_back({OP_R_ALU2, 26'($urandom())});
        pending_words.push_back({OP_R_LO, 26'h3ff_ffff});
        pending_words.push_back({OP_R_HI, 26'($urandom())});
        pending_words.push_back({OP_I_LO, 26'h000_0000});
        pending_words.push_back({OP_I_HI, 26'h3ff_ffff});
        pending_words.push_back({t_op'(OP_R_ALU2 + 1), 26'($urandom())});
        pending_words.push_back({t_op'(OP_R_LO - 1), 26'($urandom())});
        pending_words.push_back({t_op'(OP_I_HI + 1), 26'($urandom())});
        pending_words.push_back({OP_R_ALU0, 5'd5, 5'd5, 5'd5, 11'($urandom())});
        pending_words.push_back({OP_R_SH0, 5'd3, 5'd7, 5'd7, 11'($urandom())});
        pending_words.push_back({OP_I_LD0, 5'd9, 5'd9, 16'($urandom())});
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pending_words.push_back(random_word());
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || instr_bus.valid) @(posedge i_clk);
        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        while (expected_decodes.size() != 0) begin
            report_mismatch("missing result, opcode", 32'h0,
                            32'(expected_decodes[0].opcode));
            void'(expected_decodes.pop_front());
        end
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            instr_bus.valid <= 1'b0;
            dec_bus.ready <= 1'b0;
        end else begin
            if (!instr_bus.valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    instr_bus.valid <= 1'b0;
                end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                    in_gap <= $urandom_range(0, 14);
                    instr_bus.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    instr_bus.instr_word <= pending_words.pop_front();
                    instr_bus.valid <= 1'b1;
                end else begin
                    instr_bus.valid <= 1'b0;
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                dec_bus.ready <= 1'b0;
            end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                out_gap <= $urandom_range(0, 14);
                dec_bus.ready <= 1'b0;
            end else begin
                dec_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_dec want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("testbench: errors");
            $finish;
        end
        in_taken <= i_rst_n && instr_bus.valid && instr_bus.ready;
        if (i_rst_n) begin
            if (dec_bus.valid && dec_bus.ready) begin
                if (expected_decodes.size() == 0) begin
                    report_mismatch("unexpected result, opcode", 32'(dec_bus.opcode), 32'h0);
                end else begin
                    want = expected_decodes.pop_front();
                    check_field("opcode", 32'(dec_bus.opcode), 32'(want.opcode));
                    check_field("format", 32'(dec_bus.format), 32'(want.fmt));
                    check_field("src_reg_a", 32'(dec_bus.src_reg_a), 32'(want.rs));
                    check_field("src_reg_b", 32'(dec_bus.src_reg_b), 32'(want.rt));
                    check_field("dest_reg", 32'(dec_bus.dest_reg), 32'(want.rd));
                    check_field("shift_amount", 32'(dec_bus.shift_amount), 32'(want.sh));
                    check_field("imm_short", 32'(dec_bus.imm_short), 32'(want.imm16));
                    check_field("imm_long", 32'(dec_bus.imm_long), 32'(want.imm26));
                    check_field("read_mask", dec_bus.read_mask, want.read_mask);
                    check_field("write_mask", dec_bus.write_mask, want.write_mask);
                end
                result_num++;
            end
            if (instr_bus.valid && instr_bus.ready) begin
                expected_decodes.push_back(decode_word(instr_bus.instr_word));
            end
        end
    end

endmodule
